FILE: rtl/max_heap_priority_queue_top_macros.svh
// Assertion helpers for the heap queue checker.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_MACROS_SVH

// clocked assertion, off while reset is held
`define HPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, checked on every edge
`define HPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/hpq_pkg.sv
package hpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 8;
  // slot numbers are one-based; a child index may reach twice the count
  localparam int SLOT_W  = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] CAP_RESET = 8'd128;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      entry_count;
  } out_item_t;

  // controller -> datapath strobes
  typedef struct packed {
    logic       accept;
    logic       set_status;
    logic [1:0] status_code;
    logic       ins_start;
    logic       rd_par;
    logic       up_move;
    logic       place_key;
    logic       rd_ends;
    logic       rem_start;
    logic       rd_kids;
    logic       down_move;
    logic       place_last;
    logic       out_load;
  } cmd_t;

  // datapath -> controller flags
  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic at_root;
    logic leaf;
    logic up_stop;
    logic down_stop;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/hpq_dp.sv
module hpq_dp #(
  parameter int HEAP_DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hpq_pkg::in_item_t            in_data,
  input  logic                         cfg_we,
  input  logic [hpq_pkg::COUNT_W-1:0]  cfg_wdata,
  input  hpq_pkg::cmd_t                cmd,
  output hpq_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hpq_pkg::out_item_t           out_data
);

  // the count never passes 255, so slots beyond that are never used
  localparam int SLOTS = (HEAP_DEPTH < 255) ? HEAP_DEPTH : 255;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [hpq_pkg::COUNT_W-1:0] SLOTS_CNT = hpq_pkg::COUNT_W'(SLOTS);

  function automatic logic [AW-1:0] slot_addr(input hpq_pkg::slot_t s);
    return AW'(s - hpq_pkg::slot_t'(1));
  endfunction

  logic signed [hpq_pkg::KEY_W-1:0] mem [0:SLOTS-1];

  logic                             op_r;
  logic signed [hpq_pkg::KEY_W-1:0] key_r;
  logic signed [hpq_pkg::KEY_W-1:0] last_r;
  logic signed [hpq_pkg::KEY_W-1:0] removed_r;
  logic signed [hpq_pkg::KEY_W-1:0] rd0_r;
  logic signed [hpq_pkg::KEY_W-1:0] rd1_r;
  logic [1:0]                       status_r;
  logic [hpq_pkg::COUNT_W-1:0]      count_r;
  logic [hpq_pkg::COUNT_W-1:0]      cap_r;
  hpq_pkg::slot_t                   pos_r;
  hpq_pkg::slot_t                   kid_r;
  logic                             out_valid_r;
  hpq_pkg::out_item_t               out_data_r;

  hpq_pkg::slot_t                   count_slot;
  hpq_pkg::slot_t                   par;
  hpq_pkg::slot_t                   child_slot;
  logic                             pick_right;
  logic signed [hpq_pkg::KEY_W-1:0] child_key;
  logic [hpq_pkg::COUNT_W-1:0]      eff_cap;
  logic [AW-1:0]                    ra0;
  logic [AW-1:0]                    ra1;
  logic                             we;
  logic signed [hpq_pkg::KEY_W-1:0] wd;

  assign count_slot = {1'b0, count_r};
  assign par        = pos_r >> 1;
  assign pick_right = (kid_r < count_slot) && (rd0_r < rd1_r);
  assign child_key  = pick_right ? rd1_r : rd0_r;
  assign child_slot = pick_right ? kid_r + hpq_pkg::slot_t'(1) : kid_r;
  assign eff_cap    = (cap_r > SLOTS_CNT) ? SLOTS_CNT : cap_r;

  assign ra0 = cmd.rd_par  ? slot_addr(par) :
               cmd.rd_ends ? slot_addr(hpq_pkg::slot_t'(1)) : slot_addr(kid_r);
  assign ra1 = cmd.rd_kids ? slot_addr(kid_r + hpq_pkg::slot_t'(1))
                           : slot_addr(count_slot);

  assign we = cmd.up_move | cmd.place_key | cmd.down_move | cmd.place_last;
  assign wd = cmd.up_move   ? rd0_r :
              cmd.place_key ? key_r :
              cmd.down_move ? child_key : last_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[slot_addr(pos_r)] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_data.op;
      key_r     <= in_data.key;
      removed_r <= '0;
    end
    if (cmd.ins_start) begin
      pos_r <= count_slot + hpq_pkg::slot_t'(1);
    end
    if (cmd.up_move) begin
      pos_r <= par;
    end
    if (cmd.rem_start) begin
      removed_r <= rd0_r;
      last_r    <= rd1_r;
      pos_r     <= hpq_pkg::slot_t'(1);
      kid_r     <= hpq_pkg::slot_t'(2);
    end
    if (cmd.down_move) begin
      pos_r <= child_slot;
      kid_r <= {child_slot[hpq_pkg::SLOT_W-2:0], 1'b0};
    end
    if (cmd.accept) begin
      status_r <= hpq_pkg::ST_OK;
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.out_load) begin
      out_data_r.removed_key <= removed_r;
      out_data_r.status      <= status_r;
      out_data_r.entry_count <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= hpq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.ins_start) begin
        count_r <= count_r + hpq_pkg::COUNT_W'(1);
      end else if (cmd.rem_start) begin
        count_r <= count_r - hpq_pkg::COUNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.full      = (count_r >= eff_cap);
  assign sts.empty     = (count_r == '0);
  assign sts.at_root   = (pos_r == hpq_pkg::slot_t'(1));
  assign sts.leaf      = (kid_r > count_slot);
  assign sts.up_stop   = !(rd0_r < key_r);
  assign sts.down_stop = !(last_r < child_key);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/hpq_ctrl.sv
module hpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hpq_pkg::sts_t sts,
  output hpq_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DECIDE  = 11'b000_0000_0010,
    S_UP_CHK  = 11'b000_0000_0100,
    S_UP_CMP  = 11'b000_0000_1000,
    S_RM_INIT = 11'b000_0001_0000,
    S_DN_CHK  = 11'b000_0010_0000,
    S_DN_CMP  = 11'b000_0100_0000,
    S_FIN     = 11'b000_1000_0000,
    S_SPARE0  = 11'b001_0000_0000,
    S_SPARE1  = 11'b010_0000_0000,
    S_SPARE2  = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op == hpq_pkg::OP_INSERT) begin
          if (sts.full) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = hpq_pkg::ST_FULL;
            state_nxt       = S_FIN;
          end else begin
            cmd.ins_start = 1'b1;
            state_nxt     = S_UP_CHK;
          end
        end else begin
          if (sts.empty) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = hpq_pkg::ST_EMPTY;
            state_nxt       = S_FIN;
          end else begin
            cmd.rd_ends = 1'b1;
            state_nxt   = S_RM_INIT;
          end
        end
      end
      S_UP_CHK: begin
        if (sts.at_root) begin
          cmd.place_key = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.rd_par = 1'b1;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.up_stop) begin
          cmd.place_key = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end
      end
      S_RM_INIT: begin
        cmd.rem_start = 1'b1;
        state_nxt     = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.leaf) begin
          cmd.place_last = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          cmd.rd_kids = 1'b1;
          state_nxt   = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.down_stop) begin
          cmd.place_last = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          cmd.down_move = 1'b1;
          state_nxt     = S_DN_CHK;
        end
      end
      S_FIN: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/max_heap_priority_queue_top.sv
// Binary max-heap priority queue. Each input item either inserts a signed key or removes the
// current maximum; every item yields exactly one result item carrying the removed key (zero
// unless a remove succeeded), a status (ok, full, empty) and the entry count afterwards.
// Items are processed one at a time by a sequencer walking a single heap RAM with two
// registered read ports; each level moved takes a check state and a compare state. An insert
// climbs until the key reaches the root or stops under a parent that is not smaller; a remove
// sinks the moved last entry until it reaches a leaf or stops above its children. At most
// floor(log2(entries)) levels are moved. A full insert or an empty remove goes straight from
// the decision to the result. The next item can be taken in the cycle after the result is
// loaded, while that result may still wait in the output register; a stalled output holds
// the following result back. cfg_wdata sets the capacity limit (reset 128, capped at
// HEAP_DEPTH); write it only while the queue is idle.
module max_heap_priority_queue_top #(
  parameter int HEAP_DEPTH = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hpq_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hpq_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [hpq_pkg::COUNT_W-1:0]  cfg_wdata
);

  hpq_pkg::cmd_t cmd;
  hpq_pkg::sts_t sts;

  hpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpq_dp #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/hpq_checker.sv
`include "max_heap_priority_queue_top_macros.svh"

module hpq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input hpq_pkg::out_item_t out_data
);

  // a dropped or refused request never reports a key
  `HPQ_ASSERT(a_fail_no_key, out_valid && out_data.status != hpq_pkg::ST_OK |-> out_data.removed_key == '0, "key reported on failed request")

  // an empty status means nothing is held
  `HPQ_ASSERT(a_empty_count, out_valid && out_data.status == hpq_pkg::ST_EMPTY |-> out_data.entry_count == '0, "empty status with nonzero count")

  // no request is taken while one is still being worked on
  `HPQ_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken during a walk")

  // a stalled result holds
  `HPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind max_heap_priority_queue_top hpq_checker u_hpq_checker (.*);
